@@ src/lfb_pkg.sv @@
// Shared types and constants for the LIN frame builder.
// No dependencies; imported by every lfb_* module and the top level.
`timescale 1ns / 1ps

package lfb_pkg;

    // Byte kind codes as seen on the output tuser
    typedef enum logic [1:0] {
        K_SYNC  = 2'd0,
        K_PID   = 2'd1,
        K_DATA  = 2'd2,
        K_CHECK = 2'd3
    } t_kind;

    localparam logic [7:0] SYNC_BYTE     = 8'h55;
    localparam logic [5:0] DIAG_ID_RESET = 6'd60;

    // Job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified input item, ready to be serialized
    typedef struct packed {
        logic       is_read;   // header request: sync + pid only
        logic       has_hdr;   // first payload byte: sync + pid before data
        logic       has_chk;   // last payload byte: checksum after data
        logic [7:0] pid;
        logic [7:0] data;
        logic [7:0] chk;
    } t_job;

    // Protected identifier: two parity bits above the 6-bit id
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

endpackage

@@ src/lfb_front.sv @@
// Front end: accepts input beats, keeps the running checksum and builds jobs.
// Depends on lfb_pkg.
`timescale 1ns / 1ps

module lfb_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic [5:0]   i_cfg_data,
    input  logic         i_valid,
    input  logic         i_mode,
    input  logic [5:0]   i_frame_id,
    input  logic [7:0]   i_data_byte,
    input  logic         i_first_byte,
    input  logic         i_last_byte,
    input  logic         i_q_full,
    output logic         o_ready,
    output logic         o_push,
    output lfb_pkg::t_job o_job
);
    import lfb_pkg::*;

    logic [5:0] r_diag_id;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [7:0] w_pid;
    logic [7:0] w_seed;
    logic [8:0] w_add;

    assign o_ready = ~i_q_full;
    assign o_push  = i_valid & o_ready;
    assign w_pid   = protect_id(i_frame_id);

    // Seed on a frame start: zero for the diagnostic id (classic), else pid
    always_comb begin
        if (i_first_byte) begin
            w_seed = (i_frame_id == r_diag_id) ? 8'h00 : w_pid;
        end else begin
            w_seed = r_sum;
        end
        w_add = {1'b0, w_seed} + {1'b0, i_data_byte};
        // end-around carry: subtract 255 when the sum overflows
        n_sum = w_add[8] ? (w_add[7:0] + 8'd1) : w_add[7:0];
    end

    // Job for the back end
    always_comb begin
        o_job.is_read = i_mode;
        o_job.has_hdr = i_first_byte;
        o_job.has_chk = i_last_byte;
        o_job.pid     = w_pid;
        o_job.data    = i_data_byte;
        o_job.chk     = ~n_sum;
    end

    // Config register and checksum state; read requests leave the sum alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag_id <= DIAG_ID_RESET;
            r_sum     <= 8'h00;
        end else begin
            if (i_cfg_valid) begin
                r_diag_id <= i_cfg_data;
            end
            if (o_push && !i_mode) begin
                r_sum <= n_sum;
            end
        end
    end

endmodule

@@ src/lfb_queue.sv @@
// Short job queue between front and back ends, registers only.
// Depends on lfb_pkg.
`timescale 1ns / 1ps

module lfb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lfb_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output lfb_pkg::t_job o_job
);
    import lfb_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/lfb_back.sv @@
// Back end: walks each job through its output beats into the output register.
// Depends on lfb_pkg.
`timescale 1ns / 1ps

module lfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  lfb_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic [1:0]    o_kind,
    output logic          o_end
);
    import lfb_pkg::*;

    t_kind      r_step;
    t_kind      n_step;
    logic       r_busy;
    logic       n_busy;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic [1:0] r_kind;
    logic       r_end;

    t_kind      w_cur;
    t_kind      w_next;
    logic       w_last;
    logic       w_end;
    logic [7:0] w_byte;
    logic       w_load;

    // Next beat of the head job and what follows it
    always_comb begin
        if (r_busy) begin
            w_cur = r_step;
        end else begin
            w_cur = (i_job.is_read || i_job.has_hdr) ? K_SYNC : K_DATA;
        end
        case (w_cur)
            K_SYNC: begin
                w_byte = SYNC_BYTE;
                w_end  = 1'b0;
                w_last = 1'b0;
                w_next = K_PID;
            end
            K_PID: begin
                w_byte = i_job.pid;
                w_end  = i_job.is_read;
                w_last = i_job.is_read;
                w_next = K_DATA;
            end
            K_DATA: begin
                w_byte = i_job.data;
                w_end  = 1'b0;
                w_last = ~i_job.has_chk;
                w_next = K_CHECK;
            end
            K_CHECK: begin
                w_byte = i_job.chk;
                w_end  = 1'b1;
                w_last = 1'b1;
                w_next = K_SYNC;
            end
            default: begin
                w_byte = SYNC_BYTE;
                w_end  = 1'b0;
                w_last = 1'b1;
                w_next = K_SYNC;
            end
        endcase

        w_load  = i_q_valid && (!r_valid || i_ready);
        o_pop   = w_load && w_last;
        n_busy  = w_load ? ~w_last : r_busy;
        n_step  = w_load ? w_next : r_step;
        n_valid = w_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= K_SYNC;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_kind <= w_cur;
            r_end  <= w_end;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_kind  = r_kind;
    assign o_end   = r_end;

endmodule

@@ src/lin_frame_builder.sv @@
// LIN frame builder top level: front end, two-entry job queue, back end.
// An accepted input beat is written to the job queue first; its first output beat is then registered in the back end.
// Throughput: one output beat per cycle while m_axis_tready is high and a job is
// queued; an input beat makes 1 to 4 output beats of the back-end sequencer, and
// input is taken each cycle while the job queue has room. Reset (synchronous, active low) empties the queue,
// drops any output beat, clears the checksum and sets diag_frame_id to 60.
`timescale 1ns / 1ps

module lin_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: diag_frame_id
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [5:0] frame_id, [13:6] data_byte, [15:14] zero
    input  logic [1:0]  s_axis_tuser,   // [0] mode, [1] first_byte
    input  logic        s_axis_tlast,   // last_byte
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] byte_kind
    output logic        m_axis_tlast    // frame_end
);
    import lfb_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_valid;
    t_job w_job_in;
    t_job w_job_head;

    assign o_cfg_ready = 1'b1;

    lfb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .i_mode       (s_axis_tuser[0]),
        .i_frame_id   (s_axis_tdata[5:0]),
        .i_data_byte  (s_axis_tdata[13:6]),
        .i_first_byte (s_axis_tuser[1]),
        .i_last_byte  (s_axis_tlast),
        .i_q_full     (w_q_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_job        (w_job_in)
    );

    lfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_job   (w_job_head)
    );

    lfb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_job_head),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_kind    (m_axis_tuser),
        .o_end     (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // sync and data beats never close a frame
    a_no_end_on_sync_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == K_SYNC || m_axis_tuser == K_DATA)
            |-> !m_axis_tlast)
        else $error("frame end flagged on sync or data beat");

    // a taken sync beat is followed at once by its protected identifier
    a_pid_after_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == K_SYNC
            |=> m_axis_tvalid && m_axis_tuser == K_PID)
        else $error("protected identifier did not follow sync");

    // the back end only pops a job that is there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("job queue popped while empty");

    // reset leaves the output and the job queue empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !w_q_valid)
        else $error("output or queue not empty after reset");
`endif

endmodule

@@ tb/lin_frame_builder_tb.sv @@
// Self-checking testbench for lin_frame_builder: payload and header requests in,
// LIN frame bytes out, checked against an in-bench predictor. Depends on lfb_pkg.
`timescale 1ns / 1ps

module lin_frame_builder_tb;

    import lfb_pkg::*;

    localparam bit MODE_WRITE = 1'b0;
    localparam bit MODE_READ  = 1'b1;

    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int STALL_LIMIT = 3000;  // cycles without any beat before giving up
    localparam int DRAIN_WAIT  = 12;    // settle time once nothing is expected

    // Receiver stall patterns
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef struct {
        bit         mode;
        logic [5:0] id;
        logic [7:0] data;
        bit         first;
        bit         last;
    } lin_item_t;

    typedef struct {
        logic [7:0] value;
        t_kind      kind;
        logic       fend;
    } line_byte_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [5:0]  i_cfg_data    = '0;
    logic        o_cfg_ready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    lin_frame_builder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state
    logic [5:0] diag_id     = DIAG_ID_RESET;
    logic [7:0] frame_sum   = '0;
    logic       classic_sum = 1'b0;

    lin_item_t  payload_q[$];        // items waiting to be offered
    line_byte_t expected_line_q[$];  // frame bytes still to come out

    // Stimulus shaping, set per phase
    bit tx_bursty  = 1'b0;
    int rx_mode    = RX_ALWAYS;
    int hold_trig  = 0;

    // Bookkeeping
    int err_cnt     = 0;
    int n_in        = 0;
    int n_out       = 0;
    int n_frames    = 0;
    int n_classic   = 0;
    int n_reads     = 0;
    int n_cfg       = 0;
    int idle_cycles = 0;
    logic in_taken  = 1'b0;

    // Protected identifier: parity over id bits 0,1,2,4 and inverted over 1,3,4,5
    function automatic logic [7:0] protected_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = ^(id & 6'b010111);
        p1 = ~^(id & 6'b111010);
        return {p1, p0, id};
    endfunction

    function automatic void push_line(input logic [7:0] value, input t_kind kind,
                                      input logic fend);
        line_byte_t b;
        b.value = value;
        b.kind  = kind;
        b.fend  = fend;
        expected_line_q.push_back(b);
    endfunction

    // Work out the bytes one accepted item puts on the line, update the checksum
    function automatic void predict_frame_bytes(input lin_item_t it);
        logic [7:0] pid;
        logic [8:0] s;
        pid = protected_id(it.id);
        if (it.mode == MODE_READ) begin
            push_line(SYNC_BYTE, K_SYNC, 1'b0);
            push_line(pid, K_PID, 1'b1);
            n_reads++;
        end else begin
            if (it.first) begin
                classic_sum = (it.id == diag_id);
                frame_sum   = classic_sum ? 8'h00 : pid;
                push_line(SYNC_BYTE, K_SYNC, 1'b0);
                push_line(pid, K_PID, 1'b0);
                n_frames++;
                if (classic_sum)
                    n_classic++;
            end
            // end-around carry add
            s = {1'b0, frame_sum} + {1'b0, it.data};
            if (s > 9'd255)
                s = s - 9'd255;
            frame_sum = s[7:0];
            push_line(it.data, K_DATA, 1'b0);
            if (it.last)
                push_line(~frame_sum, K_CHECK, 1'b1);
        end
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_cnt++;
    endtask

    // Input driver: with tx_bursty set, bursts of beats separated by random gaps
    always @(negedge i_clk) begin : drive_input
        logic      nxt_valid;
        lin_item_t nxt;
        int        burst_left;
        int        gap_left;
        nxt_valid = s_axis_tvalid;
        nxt.mode  = s_axis_tuser[0];
        nxt.first = s_axis_tuser[1];
        nxt.last  = s_axis_tlast;
        nxt.id    = s_axis_tdata[5:0];
        nxt.data  = s_axis_tdata[13:6];
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (payload_q.size() != 0) begin
                nxt       = payload_q.pop_front();
                nxt_valid = 1'b1;
                if (tx_bursty) begin
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 10);
                        gap_left   = $urandom_range(1, 7);
                    end
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= {2'b00, nxt.data, nxt.id};
        s_axis_tuser  <= {nxt.first, nxt.mode};
        s_axis_tlast  <= nxt.last;
    end

    // Receiver: stall pattern per phase, plus an occasional long hold-off
    always @(negedge i_clk) begin : drive_ready
        int   hold_seen;
        int   hold_left;
        int   rx_cyc;
        logic rdy;
        rx_cyc++;
        if (hold_seen != hold_trig) begin
            hold_seen = hold_trig;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM:  rdy = ($urandom_range(0, 99) < 60);
                RX_PATTERN: rdy = ((rx_cyc % 7) < 4);
                default:    rdy = 1'b1;
            endcase
        end
        m_axis_tready <= rdy;
    end

    // Monitor: predict on input beats, check output beats, watch for a hang
    always @(posedge i_clk) begin : monitor
        lin_item_t  it;
        line_byte_t want;
        logic       any_beat;
        any_beat = 1'b0;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                it.mode  = s_axis_tuser[0];
                it.first = s_axis_tuser[1];
                it.last  = s_axis_tlast;
                it.id    = s_axis_tdata[5:0];
                it.data  = s_axis_tdata[13:6];
                predict_frame_bytes(it);
                n_in++;
                any_beat = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_out++;
                any_beat = 1'b1;
                if (expected_line_q.size() == 0) begin
                    report("unexpected output beat", 32'(m_axis_tdata), 32'd0);
                end else begin
                    want = expected_line_q.pop_front();
                    if (m_axis_tdata !== want.value)
                        report("out_byte", 32'(m_axis_tdata), 32'(want.value));
                    if (m_axis_tuser !== want.kind)
                        report("byte_kind", 32'(m_axis_tuser), 32'(want.kind));
                    if (m_axis_tlast !== want.fend)
                        report("frame_end", 32'(m_axis_tlast), 32'(want.fend));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                any_beat = 1'b1;
        end
        idle_cycles = any_beat ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("[lin_frame_builder] ERROR");
            $finish;
        end
    end

    task automatic queue_beat(input bit mode, input logic [5:0] id, input logic [7:0] data,
                              input bit first, input bit last);
        lin_item_t it;
        it.mode  = mode;
        it.id    = id;
        it.data  = data;
        it.first = first;
        it.last  = last;
        payload_q.push_back(it);
    endtask

    // Register write; only issued while the block is idle
    task automatic write_diag(input logic [5:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        diag_id = val;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Checked at the rising edge, where the driver's last beat has settled
    task automatic wait_idle();
        while (payload_q.size() != 0 || s_axis_tvalid || expected_line_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random content, some headers and some noise
    task automatic queue_random_traffic(input int n_items);
        int         count;
        int         pick;
        int         len;
        logic [5:0] id;
        count = 0;
        while (count < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // header request; payload fields are junk
                queue_beat(MODE_READ, 6'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
                count++;
            end else if (pick < 82) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
                id  = ($urandom_range(0, 3) == 0) ? diag_id : 6'($urandom);
                for (int k = 0; k < len; k++)
                    queue_beat(MODE_WRITE, (k == 0) ? id : 6'($urandom), 8'($urandom),
                               k == 0, k == len - 1);
                count += len;
            end else if (pick < 92) begin
                // stray byte continuing whatever sum is held
                queue_beat(MODE_WRITE, 6'($urandom), 8'($urandom), 1'b0, 1'($urandom));
                count++;
            end else begin
                // frame cut short: no last byte
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    queue_beat(MODE_WRITE, 6'($urandom), 8'($urandom), k == 0, 1'b0);
                count += len;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, register at its reset value
        tx_bursty = 1'b1;
        rx_mode   = RX_RANDOM;
        queue_beat(MODE_WRITE, 6'd0, 8'h01, 1'b0, 1'b1);   // byte with no frame start
        queue_beat(MODE_READ, 6'd0, 8'hFF, 1'b1, 1'b1);    // header, junk flags ignored
        queue_beat(MODE_READ, 6'd63, 8'h00, 1'b0, 1'b0);
        queue_beat(MODE_WRITE, DIAG_ID_RESET, 8'hFF, 1'b1, 1'b1);  // classic, one byte
        queue_beat(MODE_WRITE, 6'd0, 8'h00, 1'b1, 1'b1);           // enhanced, one byte
        queue_beat(MODE_WRITE, 6'd63, 8'hFF, 1'b1, 1'b0);          // carries wrap
        queue_beat(MODE_WRITE, 6'd0, 8'hFF, 1'b0, 1'b0);
        queue_beat(MODE_WRITE, 6'd0, 8'hFF, 1'b0, 1'b1);
        queue_beat(MODE_WRITE, 6'd5, 8'h80, 1'b0, 1'b1);           // after the checksum
        queue_beat(MODE_WRITE, DIAG_ID_RESET, 8'h01, 1'b1, 1'b0);
        queue_beat(MODE_READ, 6'd21, 8'hAA, 1'b0, 1'b1);           // header mid-frame
        queue_beat(MODE_WRITE, 6'd0, 8'hFE, 1'b0, 1'b0);
        queue_beat(MODE_WRITE, 6'd0, 8'hFF, 1'b0, 1'b1);
        queue_beat(MODE_WRITE, 6'd42, 8'h12, 1'b1, 1'b0);
        queue_beat(MODE_WRITE, 6'd17, 8'h34, 1'b1, 1'b0);          // restart mid-frame
        queue_beat(MODE_WRITE, 6'd0, 8'h56, 1'b0, 1'b1);
        queue_beat(MODE_WRITE, 6'd1, 8'hAA, 1'b1, 1'b0);
        queue_beat(MODE_WRITE, 6'd1, 8'h55, 1'b0, 1'b0);
        queue_beat(MODE_READ, DIAG_ID_RESET, 8'h00, 1'b1, 1'b0);
        queue_beat(MODE_WRITE, 6'd2, 8'h7F, 1'b0, 1'b1);
        wait_idle();

        // Random phases across several register settings
        write_diag(6'd0);
        tx_bursty = 1'b1;
        rx_mode   = RX_RANDOM;
        queue_beat(MODE_WRITE, 6'd0, 8'hC3, 1'b1, 1'b1);
        queue_random_traffic(110);
        wait_idle();

        write_diag(6'd63);
        queue_beat(MODE_WRITE, 6'd63, 8'h3C, 1'b1, 1'b1);
        queue_random_traffic(110);
        hold_trig++;    // receiver stops while the sender keeps offering
        wait_idle();

        write_diag(6'($urandom));
        tx_bursty = 1'b0;
        rx_mode   = RX_ALWAYS;
        queue_random_traffic(110);
        wait_idle();

        write_diag(DIAG_ID_RESET);
        tx_bursty = 1'b1;
        rx_mode   = RX_PATTERN;
        queue_random_traffic(110);
        wait_idle();

        $display("Covered %0d input beats (%0d frames, %0d classic, %0d headers), %0d register writes",
                 n_in, n_frames, n_classic, n_reads, n_cfg);
        $display("Checked %0d frame bytes, %0d mismatches", n_out, err_cnt);
        if (err_cnt == 0) begin
            $display("[lin_frame_builder] OK");
        end else begin
            $display("[lin_frame_builder] ERROR");
        end
        $finish;
    end

endmodule

@@ lin_frame_builder.f @@
src/lfb_pkg.sv
src/lfb_front.sv
src/lfb_queue.sv
src/lfb_back.sv
src/lin_frame_builder.sv
tb/lin_frame_builder_tb.sv
